// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define AST_RST(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion, checked during reset too
`define AST_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: sv/tvts_pkg.sv
// types, constants and rom tables of the two-voice tone synth
`default_nettype none
package tvts_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int STEPS_PER_TRACK = 16;
  localparam int TRACK_COUNT     = 3;
  localparam int STEP_W          = $clog2(STEPS_PER_TRACK);
  localparam int FREQ_W          = 17;
  localparam int NUM_W           = FREQ_W + PHASE_BITS;
  localparam int DEN_W           = 24;
  localparam int REM_W           = DEN_W + 1;
  localparam int DCNT_W          = $clog2(NUM_W + 1);
  localparam int SR_W            = 17;
  localparam int UNIT_W          = 9;
  localparam int PROD_W          = SR_W + UNIT_W;
  localparam int CNT_W           = 16;
  localparam int VOL_W           = 13;
  localparam int MS_W            = 9;
  localparam int TICK_W          = 3;
  localparam int MIX_W           = 18;
  localparam int AMP_MELODY      = 1802;
  localparam int AMP_BASS        = 1475;
  localparam int CLIP            = 29491;
  localparam int NOTE_TICK_UNITS = 115;
  localparam int MS_DIV          = 1000;
  localparam int CENTI           = 100;
  // divide by 1000 as multiply by ceil(2^36 / 1000), exact for products below 2^26
  localparam int RECIP_SHIFT     = 36;
  localparam int RECIP_W         = 27;
  localparam logic [RECIP_W-1:0] MS_RECIP = 27'd68719477;
  localparam int CPROD_W         = PROD_W + RECIP_W;
  localparam int CNT_WAIT        = 2;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_EVENT   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [1:0] CFG_SOUND_EN = 2'd0;
  localparam logic [1:0] CFG_TRACK    = 2'd1;
  localparam logic [1:0] CFG_RATE     = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] event_flags;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [3:0]         note_position;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_DIV_GO, ST_DIV_WAIT, ST_MIX
  } state_t;

  typedef enum logic [2:0] {
    OP_MEL, OP_BAS, OP_NCNT, OP_EINC, OP_ECNT
  } div_op_t;

  typedef struct packed {
    logic    capture;
    logic    restart;
    logic    silent;
    logic    div_start;
    logic    div_store;
    logic    mix;
    div_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       sound_on;
    logic       music_on;
    logic       note_due;
    logic       track_bad;
    logic       flags_nz;
    logic       div_done;
  } dp_stat_t;

  typedef struct packed {
    logic [FREQ_W-1:0] mel;
    logic [FREQ_W-1:0] bas;
    logic [TICK_W-1:0] ticks;
  } note_row_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
    logic [VOL_W-1:0]  vol;
  } tone_row_t;

  function automatic note_row_t nr(input int m, input int b, input int t);
    nr = '{mel: FREQ_W'(m), bas: FREQ_W'(b), ticks: TICK_W'(t)};
  endfunction

  function automatic note_row_t note_of(input logic [1:0] trk, input logic [3:0] stp);
    case ({trk, stp})
      6'd0:  note_of = nr(32963, 8241, 2);   6'd1:  note_of = nr(39200, 8241, 2);
      6'd2:  note_of = nr(49388, 9800, 2);   6'd3:  note_of = nr(39200, 9800, 2);
      6'd4:  note_of = nr(34923, 8731, 2);   6'd5:  note_of = nr(44000, 8731, 2);
      6'd6:  note_of = nr(52325, 11000, 2);  6'd7:  note_of = nr(44000, 11000, 2);
      6'd8:  note_of = nr(39200, 9800, 2);   6'd9:  note_of = nr(49388, 9800, 2);
      6'd10: note_of = nr(58733, 12347, 2);  6'd11: note_of = nr(49388, 12347, 2);
      6'd12: note_of = nr(34923, 8731, 2);   6'd13: note_of = nr(44000, 8731, 2);
      6'd14: note_of = nr(32963, 8241, 2);   6'd15: note_of = nr(26163, 6541, 4);
      6'd16: note_of = nr(26163, 6541, 1);   6'd17: note_of = nr(29366, 6541, 1);
      6'd18: note_of = nr(31113, 7778, 1);   6'd19: note_of = nr(39200, 7778, 1);
      6'd20: note_of = nr(36999, 7342, 2);   6'd21: note_of = nr(31113, 7342, 2);
      6'd22: note_of = nr(29366, 6541, 1);   6'd23: note_of = nr(34923, 6541, 1);
      6'd24: note_of = nr(44000, 8731, 2);   6'd25: note_of = nr(34923, 8731, 2);
      6'd26: note_of = nr(32963, 8241, 1);   6'd27: note_of = nr(39200, 8241, 1);
      6'd28: note_of = nr(49388, 9800, 2);   6'd29: note_of = nr(39200, 9800, 2);
      6'd30: note_of = nr(29366, 7342, 2);   6'd31: note_of = nr(24694, 6174, 4);
      6'd32: note_of = nr(22000, 5500, 2);   6'd33: note_of = nr(27718, 6930, 2);
      6'd34: note_of = nr(32963, 8241, 2);   6'd35: note_of = nr(41530, 10383, 2);
      6'd36: note_of = nr(39200, 9800, 1);   6'd37: note_of = nr(32963, 8241, 1);
      6'd38: note_of = nr(27718, 6930, 2);   6'd39: note_of = nr(24694, 6174, 2);
      6'd40: note_of = nr(29366, 7342, 2);   6'd41: note_of = nr(36999, 9250, 2);
      6'd42: note_of = nr(44000, 11000, 2);  6'd43: note_of = nr(55437, 13859, 2);
      6'd44: note_of = nr(49388, 12347, 1);  6'd45: note_of = nr(44000, 11000, 1);
      6'd46: note_of = nr(36999, 9250, 2);   6'd47: note_of = nr(22000, 5500, 4);
      default: note_of = nr(0, 0, 0);
    endcase
  endfunction

  function automatic tone_row_t tone_of(input logic [2:0] idx);
    case (idx)
      3'd0:    tone_of = '{FREQ_W'(11500), MS_W'(20),  VOL_W'(1638)};
      3'd1:    tone_of = '{FREQ_W'(19000), MS_W'(30),  VOL_W'(2621)};
      3'd2:    tone_of = '{FREQ_W'(7500),  MS_W'(45),  VOL_W'(3277)};
      3'd3:    tone_of = '{FREQ_W'(33000), MS_W'(110), VOL_W'(3932)};
      3'd4:    tone_of = '{FREQ_W'(52200), MS_W'(180), VOL_W'(4588)};
      3'd5:    tone_of = '{FREQ_W'(66000), MS_W'(180), VOL_W'(3932)};
      3'd6:    tone_of = '{FREQ_W'(5500),  MS_W'(500), VOL_W'(5898)};
      default: tone_of = '{FREQ_W'(88000), MS_W'(420), VOL_W'(4260)};
    endcase
  endfunction

  // index of the highest set flag
  function automatic logic [2:0] top_flag(input logic [7:0] flags);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (flags[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: sv/tvts_datapath.sv
// voice state, shared restoring divider, count multiplier and sample mixer
`default_nettype none
module tvts_datapath import tvts_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [SR_W-1:0] cfg_data,
  input  in_item_t        in_data,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  output out_item_t       mix_item
);

  logic                  sound_enabled;
  logic [2:0]            track_select;
  logic [SR_W-1:0]       sample_rate_hz;
  logic [1:0]            req_q;
  logic [7:0]            flags_q;
  logic [STEP_W-1:0]     step_index;
  logic [CNT_W-1:0]      note_samples_left;
  logic [PHASE_BITS-1:0] melody_phase, bass_phase, effect_phase;
  logic [PHASE_BITS-1:0] melody_increment, bass_increment, effect_increment;
  logic [CNT_W-1:0]      effect_samples_left;
  logic [VOL_W-1:0]      effect_volume;

  logic [NUM_W-1:0]      div_num;
  logic [REM_W-1:0]      div_rem;
  logic [DEN_W-1:0]      div_den;
  logic [PHASE_BITS-1:0] div_quo;
  logic [DCNT_W-1:0]     div_cnt;
  logic                  div_zero;
  logic [PROD_W-1:0]     prod;
  logic [CPROD_W-1:0]    cnt_prod;

  note_row_t             row;
  tone_row_t             tone;
  logic [UNIT_W-1:0]     units;
  logic                  is_count;
  logic [FREQ_W-1:0]     freq_sel;
  logic [NUM_W-1:0]      num_in;
  logic [DEN_W-1:0]      den_in;
  logic [REM_W-1:0]      rem_sh;
  logic                  rem_ge;
  logic [PHASE_BITS-1:0] inc_res;
  logic [CNT_W-1:0]      cnt_res;
  logic [STEP_W-1:0]     step_next;

  logic                     music, mel_on, bas_on, eff_on;
  logic [15:0]              tri_t;
  logic signed [MIX_W-1:0]  tri_v;
  logic signed [28:0]       tri_p;
  logic signed [28:0]       tri_q;
  logic signed [MIX_W-1:0]  s_mel, s_bas, s_eff, s_sum;
  logic signed [15:0]       s_clip;

  assign row      = note_of(track_select[1:0], step_index);
  assign tone     = tone_of(top_flag(flags_q));
  assign units    = (req_q == REQ_EVENT) ? tone.ms
                                         : UNIT_W'(NOTE_TICK_UNITS * row.ticks);
  assign is_count = (cmd.op == OP_NCNT) || (cmd.op == OP_ECNT);
  assign freq_sel = (cmd.op == OP_MEL) ? row.mel :
                    (cmd.op == OP_BAS) ? row.bas : tone.freq;
  assign num_in   = is_count ? NUM_W'(prod) : {freq_sel, {PHASE_BITS{1'b0}}};
  assign den_in   = is_count ? DEN_W'(MS_DIV) : DEN_W'(sample_rate_hz) * DEN_W'(CENTI);
  assign rem_sh   = {div_rem[DEN_W-1:0], div_num[NUM_W-1]};
  assign rem_ge   = rem_sh >= REM_W'(div_den);
  assign inc_res  = div_zero ? '0 : div_quo;
  assign cnt_res  = (|cnt_prod[CPROD_W-1:RECIP_SHIFT+CNT_W]) ? {CNT_W{1'b1}}
                                                             : cnt_prod[RECIP_SHIFT +: CNT_W];
  assign step_next = (step_index == STEP_W'(STEPS_PER_TRACK - 1)) ? '0 : step_index + 1'b1;

  assign music  = sound_enabled && !track_select[2];
  assign mel_on = music && (melody_increment != '0);
  assign bas_on = music && (bass_increment != '0);
  assign eff_on = sound_enabled && (effect_samples_left != '0) && (effect_increment != '0);

  // triangle from the top phase bits, scaled with truncation toward zero
  assign tri_t = bass_phase[PHASE_BITS-1 -: 16];
  assign tri_v = !tri_t[15] ? $signed({1'b0, tri_t, 1'b0}) - MIX_W'(32768)
                            : MIX_W'(98304) - $signed({1'b0, tri_t, 1'b0});
  assign tri_p = 29'(tri_v) * 29'(AMP_BASS);
  assign tri_q = tri_p[28] ? (tri_p + 29'(32767)) >>> 15 : tri_p >>> 15;

  assign s_mel = !mel_on ? '0 : melody_phase[PHASE_BITS-1] ? -MIX_W'(AMP_MELODY)
                                                           : MIX_W'(AMP_MELODY);
  assign s_bas = bas_on ? MIX_W'(tri_q) : '0;
  assign s_eff = !eff_on ? '0 : effect_phase[PHASE_BITS-1]
                 ? -$signed({5'b0, effect_volume}) : $signed({5'b0, effect_volume});
  assign s_sum = s_mel + s_bas + s_eff;
  assign s_clip = (s_sum > MIX_W'(CLIP))  ? 16'(CLIP) :
                  (s_sum < -MIX_W'(CLIP)) ? -16'(CLIP) : 16'(s_sum);

  assign mix_item.sample_out    = s_clip;
  assign mix_item.note_position = 4'(step_index);

  assign stat.req       = req_q;
  assign stat.sound_on  = sound_enabled;
  assign stat.music_on  = !track_select[2];
  assign stat.note_due  = note_samples_left == '0;
  assign stat.track_bad = track_select[1:0] >= 2'(TRACK_COUNT);
  assign stat.flags_nz  = flags_q != '0;
  assign stat.div_done  = div_cnt == '0;

  always_ff @(posedge clk) begin
    prod     <= PROD_W'(sample_rate_hz) * PROD_W'(units);
    cnt_prod <= CPROD_W'(prod) * CPROD_W'(MS_RECIP);
    if (cmd.capture) begin
      req_q   <= in_data.req_type;
      flags_q <= in_data.event_flags;
    end
    if (cmd.div_start) begin
      div_num  <= num_in;
      div_den  <= den_in;
      div_rem  <= '0;
      div_quo  <= '0;
      div_zero <= den_in == '0;
    end else if (div_cnt != '0) begin
      div_num <= {div_num[NUM_W-2:0], 1'b0};
      div_rem <= rem_ge ? rem_sh - REM_W'(div_den) : rem_sh;
      div_quo <= {div_quo[PHASE_BITS-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enabled       <= 1'b1;
      track_select        <= '0;
      sample_rate_hz      <= SR_W'(48000);
      step_index          <= '0;
      note_samples_left   <= '0;
      melody_phase        <= '0;
      bass_phase          <= '0;
      effect_phase        <= '0;
      melody_increment    <= '0;
      bass_increment      <= '0;
      effect_increment    <= '0;
      effect_samples_left <= '0;
      effect_volume       <= '0;
      div_cnt             <= '0;
    end else begin
      if (cmd.div_start) begin
        div_cnt <= is_count ? DCNT_W'(CNT_WAIT) : DCNT_W'(NUM_W);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (cmd.restart) begin
        step_index        <= '0;
        note_samples_left <= '0;
        melody_phase      <= '0;
        bass_phase        <= '0;
      end
      if (cmd.silent) begin
        melody_increment  <= '0;
        bass_increment    <= '0;
        note_samples_left <= '0;
      end
      if (cmd.div_store) begin
        case (cmd.op)
          OP_MEL:  melody_increment <= inc_res;
          OP_BAS:  bass_increment   <= inc_res;
          OP_NCNT: begin
            note_samples_left <= cnt_res;
            step_index        <= step_next;
          end
          OP_EINC: effect_increment <= inc_res;
          OP_ECNT: begin
            effect_samples_left <= cnt_res;
            effect_volume       <= tone.vol;
            effect_phase        <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.mix) begin
        if (mel_on) melody_phase <= melody_phase + melody_increment;
        if (bas_on) bass_phase <= bass_phase + bass_increment;
        if (music && note_samples_left != '0) note_samples_left <= note_samples_left - 1'b1;
        if (eff_on) begin
          effect_phase        <= effect_phase + effect_increment;
          effect_samples_left <= effect_samples_left - 1'b1;
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SOUND_EN: begin
            sound_enabled <= cfg_data[0];
            if (!cfg_data[0]) effect_samples_left <= '0;
          end
          CFG_TRACK: track_select   <= cfg_data[2:0];
          CFG_RATE:  sample_rate_hz <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/tvts_ctrl.sv
// controller sequencing requests, note loads and effect loads
`default_nettype none
module tvts_ctrl import tvts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_free,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  cmd
);

  state_t  state, state_next;
  div_op_t op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_MEL;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.req)
          REQ_TICK: begin
            if (stat.sound_on && stat.music_on && stat.note_due) begin
              if (stat.track_bad) begin
                cmd.silent = 1'b1;
                state_next = ST_MIX;
              end else begin
                op_next    = OP_MEL;
                state_next = ST_DIV_GO;
              end
            end else begin
              state_next = ST_MIX;
            end
          end
          REQ_EVENT: begin
            if (stat.sound_on && stat.flags_nz) begin
              op_next    = OP_EINC;
              state_next = ST_DIV_GO;
            end else begin
              state_next = ST_IDLE;
            end
          end
          REQ_RESTART: begin
            cmd.restart = 1'b1;
            state_next  = ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          unique case (op)
            OP_MEL:  begin op_next = OP_BAS;  state_next = ST_DIV_GO; end
            OP_BAS:  begin op_next = OP_NCNT; state_next = ST_DIV_GO; end
            OP_NCNT: state_next = ST_MIX;
            OP_EINC: begin op_next = OP_ECNT; state_next = ST_DIV_GO; end
            OP_ECNT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_MIX: begin
        if (out_free) begin
          cmd.mix    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/two_voice_tone_synth_core.sv
// top level of the two-voice tone synth: controller, datapath, output register
//
// channel  direction  payload            transfer when
// in       in         in_item_t          in_valid && in_ready
// out      out        out_item_t         out_valid && out_ready
// cfg      in         cfg_index/cfg_data cfg_valid && cfg_ready
//
// a tick without a note load passes IDLE, DECODE and MIX, where MIX waits for out_free
// a note load adds 2 divisions on the shared restoring divider
// and a note length step through the reciprocal multiplier
// an event with a flag set and sound on takes 1 division and a length step, others end after decode
// one item at a time; the next item is taken while a result waits in the output register
// synchronous reset, no clearing pass; cfg is always ready
`default_nettype none
module two_voice_tone_synth_core import tvts_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [SR_W-1:0] cfg_data
);

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t mix_item;
  logic      out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  tvts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tvts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .mix_item  (mix_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.mix) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) out_data <= mix_item;
  end

endmodule
`default_nettype wire

// File: sv/tvts_checker.sv
// port-level checks of the two-voice tone synth, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module tvts_props import tvts_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input in_item_t        in_data,
  input logic            out_valid,
  input logic            out_ready,
  input out_item_t       out_data,
  input logic            cfg_valid,
  input logic            cfg_ready,
  input logic [1:0]      cfg_index,
  input logic [SR_W-1:0] cfg_data
);

  `AST_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `AST_ALWAYS(a_out_reset, clk, $past(rst) |-> !out_valid)
  `AST_RST(a_busy_after_take, clk, rst, in_valid && in_ready |=> !in_ready)
  `AST_RST(a_cfg_open, clk, rst, cfg_ready)

endmodule

bind two_voice_tone_synth_core tvts_props u_chk (.*);
`default_nettype wire
